/* design/assert_macros.svh */
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/pbrd_pkg.sv */
// ----------------------------------------------------------------------------
// pbrd_pkg
// Shared types and constants of the pulse beat rate detector.
// ----------------------------------------------------------------------------
package pbrd_pkg;

  localparam logic [15:0] BPM_CONST     = 16'd60000;
  localparam logic [15:0] INTERVAL_SEED = 16'd600;
  localparam logic [7:0]  PERIOD_RST    = 8'd2;
  localparam logic [15:0] GAP_RST       = 16'd250;
  localparam logic [15:0] TIMEOUT_RST   = 16'd2500;
  localparam int unsigned SEED_RST      = 512;
  localparam int unsigned AMP_RST       = 100;

  localparam logic [1:0] REG_PERIOD  = 2'd0;
  localparam logic [1:0] REG_GAP     = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_SEED    = 2'd3;

  // Job handed from the front end to the rate back end.
  typedef enum logic [1:0] {
    JOB_NONE  = 2'd0,  // emit result with current bpm
    JOB_SEED  = 2'd1,  // fill history, no bpm update
    JOB_SEED_BPM = 2'd2, // fill history then compute bpm
    JOB_SHIFT = 2'd3   // shift in interval and compute bpm
  } job_e;

endpackage

/* design/pbrd_if.sv */
// ----------------------------------------------------------------------------
// pbrd_stream_if
// Valid/ready channel carrying a payload of PW bits.
// ----------------------------------------------------------------------------
interface pbrd_stream_if #(
  parameter int PW = 8
) ();
  logic          valid;
  logic          ready;
  logic [PW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/pulse_beat_rate_detector.sv */
// ----------------------------------------------------------------------------
// pulse_beat_rate_detector
// Pulse-sensor beat detector with averaged beats-per-minute output.
// ----------------------------------------------------------------------------
// One result per sample. The front end tracks each sample and hands a job
// through a two-entry queue to the back end. A sample without a rate update
// goes straight to the output register; when a beat updates the rate the back
// end runs a serial history sum, then a 16-step restoring divide of 60000 by
// the mean, and a seed fills every history entry first. Sustained rate is set
// by the back end.
module pulse_beat_rate_detector import pbrd_pkg::*; #(
  parameter int HISTORY_DEPTH = 10,
  parameter int SAMPLE_BITS   = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  pbrd_stream_if.sink   in_s,
  pbrd_stream_if.source out_s
);
  localparam int QW = 2 + 16 + 1 + SAMPLE_BITS + 16;
  localparam int SB = SAMPLE_BITS;

  logic [7:0]    period_q;
  logic [15:0]   gap_q, tmo_q;
  logic [SB-1:0] seed_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      gap_q    <= GAP_RST;
      tmo_q    <= TIMEOUT_RST;
      seed_q   <= SB'(SEED_RST);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PERIOD:  period_q <= cfg_data_i[7:0];
        REG_GAP:     gap_q    <= cfg_data_i;
        REG_TIMEOUT: tmo_q    <= cfg_data_i;
        REG_SEED:    seed_q   <= cfg_data_i[SB-1:0];
        default: ;
      endcase
    end
  end

  // two-entry queue
  logic [QW-1:0] qd_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          fire;
  job_e          job;
  logic [15:0]   ivl;
  logic          pulse;
  logic [SB-1:0] amp;

  pbrd_stream_if #(.PW(QW)) q_if ();

  assign in_s.ready = cnt_q != 2'd2;
  assign fire = in_s.valid && in_s.ready;

  pbrd_front #(.SB(SB)) u_front (
    .clk_i, .rst_ni, .fire_i(fire), .sample_i(in_s.data[SB-1:0]),
    .period_i(period_q), .gap_i(gap_q), .timeout_i(tmo_q), .seed_i(seed_q),
    .job_o(job), .interval_o(ivl), .pulse_o(pulse), .amp_o(amp)
  );

  assign q_if.valid = cnt_q != 2'd0;
  assign q_if.data  = qd_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (fire) qd_q[wp_q] <= {job, ivl, 16'd0, pulse, amp};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (fire) wp_q <= ~wp_q;
      if (q_if.valid && q_if.ready) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(fire) - 2'(q_if.valid && q_if.ready);
    end
  end

  pbrd_back #(.HD(HISTORY_DEPTH), .SB(SB), .QW(QW)) u_back (
    .clk_i, .rst_ni, .q_in(q_if.sink), .res_out(out_s)
  );

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_q_bound, clk_i, rst_ni, 1'b1, cnt_q != 2'd3, "queue count overflow")
  `ASSERT_IMPL(a_q_nopop, clk_i, rst_ni, cnt_q == 2'd0, !q_if.valid, "pop from empty queue")
  `ASSERT_NEXT(a_q_push, clk_i, rst_ni, fire && !(q_if.valid && q_if.ready),
               cnt_q != 2'd0, "push lost")
endmodule

/* design/pbrd_front.sv */
// ----------------------------------------------------------------------------
// pbrd_front
// Per-sample tracking: clock, peak/trough, threshold, beat and timeout.
// ----------------------------------------------------------------------------
module pbrd_front import pbrd_pkg::*; #(
  parameter int SB = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [SB-1:0] sample_i,
  input  logic [7:0]    period_i,
  input  logic [15:0]   gap_i,
  input  logic [15:0]   timeout_i,
  input  logic [SB-1:0] seed_i,
  output job_e          job_o,
  output logic [15:0]   interval_o,
  output logic          pulse_o,
  output logic [SB-1:0] amp_o
);
  logic [31:0]   clk_q, last_q;
  logic [SB-1:0] peak_q, trough_q, thr_q, amp_q;
  logic [15:0]   ivl_q;
  logic          inp_q, first_q, second_q;

  logic [31:0]   clk_n, el;
  logic [SB-1:0] peak_n, trough_n, thr_n, amp_n, diff;
  logic [15:0]   ivl_n, gate;
  logic [31:0]   last_n;
  logic          inp_n, first_n, second_n, beat;
  job_e          job;
  logic [33:0]   g5;

  // gate = (interval/5)*3 from the stored interval; reciprocal of 5 on 16 bits
  always_comb begin
    g5 = 34'(ivl_q) * 34'd52429;
    gate = 16'(g5[33:18]) * 16'd3;
  end

  always_comb begin
    clk_n    = clk_q + 32'(period_i);
    el       = clk_n - last_q;
    peak_n   = peak_q;
    trough_n = trough_q;
    thr_n    = thr_q;
    amp_n    = amp_q;
    ivl_n    = ivl_q;
    last_n   = last_q;
    inp_n    = inp_q;
    first_n  = first_q;
    second_n = second_q;
    job      = JOB_NONE;
    diff     = '0;
    if (sample_i < thr_q && el > 32'(gate) && sample_i < trough_q) trough_n = sample_i;
    if (sample_i > thr_q && sample_i > peak_q) peak_n = sample_i;
    beat = el > 32'(gap_i) && sample_i > thr_q && !inp_q && el > 32'(gate);
    if (beat) begin
      inp_n  = 1'b1;
      ivl_n  = (el > 32'hFFFF) ? 16'hFFFF : el[15:0];
      last_n = clk_n;
      if (second_q) second_n = 1'b0;
      if (first_q) begin
        first_n  = 1'b0;
        second_n = 1'b1;
        job      = second_q ? JOB_SEED : JOB_NONE;
      end else begin
        job = second_q ? JOB_SEED_BPM : JOB_SHIFT;
      end
    end
    if (!(beat && first_q)) begin
      if (sample_i < thr_n && inp_n) begin
        inp_n    = 1'b0;
        diff     = (peak_n >= trough_n) ? peak_n - trough_n : '0;
        amp_n    = diff;
        thr_n    = SB'({1'b0, diff[SB-1:1]} + trough_n);
        peak_n   = thr_n;
        trough_n = thr_n;
      end
      if (el > 32'(timeout_i)) begin
        thr_n    = seed_i;
        peak_n   = seed_i;
        trough_n = seed_i;
        last_n   = clk_n;
        first_n  = 1'b1;
        second_n = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_q    <= '0;
      last_q   <= '0;
      peak_q   <= SB'(SEED_RST);
      trough_q <= SB'(SEED_RST);
      thr_q    <= SB'(SEED_RST);
      amp_q    <= SB'(AMP_RST);
      ivl_q    <= INTERVAL_SEED;
      inp_q    <= 1'b0;
      first_q  <= 1'b1;
      second_q <= 1'b0;
    end else if (fire_i) begin
      clk_q    <= clk_n;
      last_q   <= last_n;
      peak_q   <= peak_n;
      trough_q <= trough_n;
      thr_q    <= thr_n;
      amp_q    <= amp_n;
      ivl_q    <= ivl_n;
      inp_q    <= inp_n;
      first_q  <= first_n;
      second_q <= second_n;
    end
  end

  assign job_o      = job;
  assign interval_o = ivl_n;
  assign pulse_o    = inp_n;
  assign amp_o      = amp_n;

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_flags_excl, clk_i, rst_ni, 1'b1, !(first_q && second_q), "both pending")
  `ASSERT_NEXT(a_beat_pulse, clk_i, rst_ni, fire_i && beat, inp_q || first_q,
               "beat did not enter pulse")
  `ASSERT_IMPL(a_amp_seed, clk_i, rst_ni, fire_i && job == JOB_SEED, second_q,
               "seed without pending")
endmodule

/* design/pbrd_back.sv */
// ----------------------------------------------------------------------------
// pbrd_back
// Interval history, serial sum and serial divide for the rate.
// ----------------------------------------------------------------------------
module pbrd_back import pbrd_pkg::*; #(
  parameter int HD = 10,
  parameter int SB = 10,
  parameter int QW = 2 + 16 + 16 + 1 + SB
) (
  input  logic clk_i,
  input  logic rst_ni,
  pbrd_stream_if.sink   q_in,
  pbrd_stream_if.source res_out
);
  localparam int IW = $clog2(HD);
  localparam int TW = 16 + $clog2(HD + 1);
  localparam int OW = 1 + 16 + 16 + 1 + SB;
  // reciprocal of HD, exact for every TW-bit total
  localparam int RS = TW + $clog2(HD);
  localparam logic [TW:0] RM = (TW+1)'(((64'd1 << RS) + 64'(HD) - 64'd1) / 64'(HD));

  typedef enum logic [2:0] {S_IDLE, S_FILL, S_SUM, S_MEAN, S_DIV, S_OUT} st_e;

  st_e           st_q;
  logic [15:0]   hist_q [HD];
  logic [IW-1:0] idx_q;
  logic [TW-1:0] tot_q;
  logic [15:0]   ivl_q, bpm_q, mean_q, rem_q;
  logic [15:0]   quo_q;
  logic [4:0]    bit_q;
  logic          inp_q, found_q, shift_q;
  logic [SB-1:0] amp_q;
  logic          ovalid_q;
  logic [OW-1:0] odata_q;
  job_e          job;
  logic [TW-1:0] mean_full;
  logic [2*TW:0] mean_prod;
  logic [16:0]   rtry;

  assign job = job_e'(q_in.data[QW-1 -: 2]);
  // S_OUT waits for the output register, so a held result stalls intake from the queue
  assign q_in.ready = st_q == S_IDLE;
  assign res_out.valid = ovalid_q;
  assign res_out.data  = odata_q;
  assign mean_prod = (2*TW+1)'(tot_q) * (2*TW+1)'(RM);
  assign mean_full = mean_prod[RS +: TW];
  assign rtry = {rem_q, BPM_CONST[bit_q[3:0]]} - {1'b0, mean_q};

  always_ff @(posedge clk_i) begin
    if (st_q == S_FILL || (st_q == S_SUM && shift_q)) begin
      if (shift_q && 32'(idx_q) < HD - 1) hist_q[idx_q] <= hist_q[idx_q + IW'(1)];
      else hist_q[idx_q] <= ivl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      ovalid_q <= 1'b0;
      bpm_q    <= '0;
      idx_q    <= '0;
      tot_q    <= '0;
      shift_q  <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      if (res_out.valid && res_out.ready) ovalid_q <= 1'b0;
      unique case (st_q)
        S_IDLE: if (q_in.valid && q_in.ready) begin
          ivl_q   <= q_in.data[QW-3 -: 16];
          inp_q   <= q_in.data[SB];
          amp_q   <= q_in.data[SB-1:0];
          idx_q   <= '0;
          tot_q   <= '0;
          found_q <= job != JOB_NONE && job != JOB_SEED;
          shift_q <= job == JOB_SHIFT;
          unique case (job)
            JOB_NONE:  st_q <= S_OUT;
            JOB_SEED:  st_q <= S_FILL;
            JOB_SEED_BPM: st_q <= S_FILL;
            JOB_SHIFT: st_q <= S_SUM;
            default:   st_q <= S_OUT;
          endcase
        end
        S_FILL: begin
          if (32'(idx_q) == HD - 1) begin
            idx_q <= '0;
            st_q  <= found_q ? S_SUM : S_OUT;
            shift_q <= found_q;
          end else idx_q <= idx_q + IW'(1);
        end
        S_SUM: begin
          // shifted value equals new entry at this index
          tot_q <= tot_q + TW'((32'(idx_q) < HD - 1) ? hist_q[idx_q + IW'(1)] : ivl_q);
          if (32'(idx_q) == HD - 1) st_q <= S_MEAN;
          else idx_q <= idx_q + IW'(1);
        end
        S_MEAN: begin
          mean_q <= (mean_full > TW'(16'hFFFF)) ? 16'hFFFF : mean_full[15:0];
          rem_q  <= '0;
          quo_q  <= '0;
          bit_q  <= 5'd15;
          st_q   <= S_DIV;
        end
        S_DIV: begin
          if (mean_q == '0) begin
            bpm_q <= BPM_CONST;
            st_q  <= S_OUT;
          end else begin
            if (!rtry[16]) begin
              rem_q <= rtry[15:0];
              quo_q <= quo_q | (16'd1 << bit_q[3:0]);
            end else rem_q <= {rem_q[14:0], BPM_CONST[bit_q[3:0]]};
            if (bit_q == 5'd0) begin
              bpm_q <= quo_q | (rtry[16] ? 16'd0 : 16'd1);
              st_q  <= S_OUT;
            end
            bit_q <= bit_q - 5'd1;
          end
        end
        S_OUT: if (!ovalid_q) begin
          ovalid_q <= 1'b1;
          odata_q  <= {found_q, bpm_q, ivl_q, inp_q, amp_q};
          st_q     <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_idle_ready, clk_i, rst_ni, q_in.ready, st_q == S_IDLE, "ready outside idle")
  `ASSERT_NEXT(a_out_idle, clk_i, rst_ni, st_q == S_OUT && !ovalid_q,
               ovalid_q && st_q == S_IDLE, "result not posted")
  `ASSERT_IMPL(a_div_mean, clk_i, rst_ni, st_q == S_DIV, bit_q < 5'd16, "divider overrun")
endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pulse beat rate detector: a directed table after
// reset, then phases of synthetic pulse trains and noise under several register
// settings, with bursty input, stalling output and per-field result checks.
// ----------------------------------------------------------------------------
module tb_top import pbrd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NHIST       = 10;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 80;

  typedef struct packed {
    logic        found;
    logic [15:0] bpm;
    logic [15:0] ivl;
    logic        active;
    logic [9:0]  amp;
  } beat_res_t;

  typedef struct {
    logic [9:0] s;
    bit         typed;
    beat_res_t  res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_PERIOD;
  logic [15:0] cfg_data_i = '0;

  pbrd_stream_if #(.PW(10)) in_if ();
  pbrd_stream_if #(.PW(44)) out_if ();

  pulse_beat_rate_detector dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_s       (in_if),
    .out_s      (out_if)
  );

  always #10 clk_i = ~clk_i;

  // detector model state
  logic [7:0]  m_period;
  logic [15:0] m_gap, m_tmo;
  logic [9:0]  m_seed;
  logic [31:0] m_clock, m_last_beat;
  logic [9:0]  m_peak, m_trough, m_thresh, m_amp;
  logic [15:0] m_ivl, m_bpm;
  logic [15:0] m_hist [NHIST];
  bit          m_in_pulse, m_first, m_second;

  logic [9:0] sample_q [$];
  beat_res_t  beat_q [$];
  int errors = 0;
  int cycles = 0;
  int gap_max = 6;
  int sink_mode = 0;
  int hold_cycles = 0;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void model_reset();
    m_period = PERIOD_RST; m_gap = GAP_RST; m_tmo = TIMEOUT_RST; m_seed = 10'(SEED_RST);
    m_clock = '0; m_last_beat = '0;
    m_peak = 10'(SEED_RST); m_trough = 10'(SEED_RST); m_thresh = 10'(SEED_RST);
    m_ivl = INTERVAL_SEED; m_bpm = '0; m_amp = 10'(AMP_RST);
    m_in_pulse = 0; m_first = 1; m_second = 0;
    foreach (m_hist[k]) m_hist[k] = '0;
  endfunction

  function automatic beat_res_t track_sample(logic [9:0] s);
    logic [31:0] elapsed, gate, total, mean;
    beat_res_t r;
    bit found, done;
    found = 0; done = 0;
    m_clock = m_clock + m_period;
    elapsed = m_clock - m_last_beat;
    gate = (32'(m_ivl) / 5) * 3;
    if (s < m_thresh && elapsed > gate && s < m_trough) m_trough = s;
    if (s > m_thresh && s > m_peak) m_peak = s;
    if (elapsed > m_gap && s > m_thresh && !m_in_pulse && elapsed > gate) begin
      m_in_pulse = 1;
      m_ivl = (elapsed > 32'hFFFF) ? 16'hFFFF : elapsed[15:0];
      m_last_beat = m_clock;
      if (m_second) begin
        m_second = 0;
        foreach (m_hist[k]) m_hist[k] = m_ivl;
      end
      if (m_first) begin
        // first beat only arms the history
        m_first = 0;
        m_second = 1;
        done = 1;
      end else begin
        total = 0;
        for (int k = 0; k < NHIST - 1; k++) begin
          m_hist[k] = m_hist[k + 1];
          total += m_hist[k];
        end
        m_hist[NHIST - 1] = m_ivl;
        total += m_ivl;
        mean = total / NHIST;
        if (mean > 32'hFFFF) mean = 32'hFFFF;
        m_bpm = (mean == 0) ? BPM_CONST : 16'(32'(BPM_CONST) / mean);
        found = 1;
      end
    end
    if (!done) begin
      if (s < m_thresh && m_in_pulse) begin
        m_in_pulse = 0;
        m_amp = (m_peak >= m_trough) ? m_peak - m_trough : '0;
        m_thresh = 10'((11'(m_amp) >> 1) + 11'(m_trough));
        m_peak = m_thresh;
        m_trough = m_thresh;
      end
      if (elapsed > m_tmo) begin
        m_thresh = m_seed; m_peak = m_seed; m_trough = m_seed;
        m_last_beat = m_clock;
        m_first = 1;
        m_second = 0;
      end
    end
    r.found = found; r.bpm = m_bpm; r.ivl = m_ivl; r.active = m_in_pulse; r.amp = m_amp;
    return r;
  endfunction

  function automatic void queue_sample(logic [9:0] s, bit typed = 0,
                                       beat_res_t want = '0);
    beat_res_t r;
    r = track_sample(s);
    beat_q.push_back(typed ? want : r);
    sample_q.push_back(s);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_PERIOD:  m_period = val[7:0];
      REG_GAP:     m_gap = val;
      REG_TIMEOUT: m_tmo = val;
      REG_SEED:    m_seed = val[9:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    wait (sample_q.size() == 0 && beat_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Pulse train: beats of bmin..bmax samples with short high phases; some noise.
  task automatic pulse_train(int n, int bmin, int bmax);
    int pos, len, hi_len;
    pos = 0; len = 1; hi_len = 1;
    for (int i = 0; i < n; i++) begin
      if (pos == 0) begin
        len = $urandom_range(bmax, bmin);
        hi_len = $urandom_range((len + 2) / 3, 1);
      end
      if ($urandom_range(99, 0) < 12)
        queue_sample(10'($urandom));
      else if (pos < hi_len)
        queue_sample(10'($urandom_range(1023, 640)));
      else
        queue_sample(10'($urandom_range(380, 0)));
      pos = (pos + 1 >= len) ? 0 : pos + 1;
    end
  endtask

  // sender: bursts with random gaps
  always @(posedge clk_i) begin
    int burst_left, gap_left;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) void'(sample_q.pop_front());
      if (!(in_if.valid && !in_if.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          in_if.valid <= 1'b1;
          in_if.data  <= sample_q[0];
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(24, 1);
            gap_left = $urandom_range(gap_max, 0);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: result check and stall pattern
  always @(posedge clk_i) begin
    beat_res_t got, want;
    int tick;
    if (rst_ni) begin
      tick++;
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (beat_q.size() == 0) begin
          report("result with none expected", 32'd1, 32'd0);
        end else begin
          want = beat_q.pop_front();
          if (got.found !== want.found)
            report("beat_found", 32'(got.found), 32'(want.found));
          if (got.bpm !== want.bpm) report("bpm", 32'(got.bpm), 32'(want.bpm));
          if (got.ivl !== want.ivl)
            report("beat_interval_ms", 32'(got.ivl), 32'(want.ivl));
          if (got.active !== want.active)
            report("pulse_active", 32'(got.active), 32'(want.active));
          if (got.amp !== want.amp) report("amplitude", 32'(got.amp), 32'(want.amp));
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        case (sink_mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(3, 0) != 0);
          default: out_if.ready <= (tick % 7 < 3);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    dir_row_t rows [$];
    beat_res_t idle_res;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    model_reset();
    idle_res = '{found: 0, bpm: 0, ivl: INTERVAL_SEED, active: 0, amp: 10'(AMP_RST)};
    // no beat can register this early after reset
    rows = '{
      '{10'd0, 1, idle_res}, '{10'd1023, 1, idle_res}, '{10'd512, 1, idle_res},
      '{10'd511, 1, idle_res}, '{10'd513, 0, '0}, '{10'h2AA, 0, '0},
      '{10'h155, 0, '0}, '{10'd0, 0, '0}, '{10'd1, 0, '0}, '{10'd1022, 0, '0},
      '{10'd300, 0, '0}, '{10'd800, 0, '0}, '{10'd0, 0, '0}, '{10'd1023, 0, '0}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) queue_sample(rows[i].s, rows[i].typed, rows[i].res);
    wait_drained();

    // period, gap, timeout, seed, items, beat length range, sender gap, sink mode
    for (int p = 0; p < 6; p++) begin
      int per, gap, tmo, seed, n, bmin, bmax, gm, sm;
      case (p)
        0: begin per = 20;  gap = 250;   tmo = 2500;  seed = 512;  n = 300;
                 bmin = 15;  bmax = 40;  gm = 6; sm = 1; end
        1: begin per = 255; gap = 0;     tmo = 65535; seed = 1023; n = 60;
                 bmin = 2;   bmax = 6;   gm = 0; sm = 0; end
        2: begin per = 1;   gap = 65535; tmo = 0;     seed = 0;    n = 60;
                 bmin = 2;   bmax = 8;   gm = 3; sm = 2; end
        3: begin per = 5;   gap = 100;   tmo = 3000;  seed = 300;  n = 420;
                 bmin = 30;  bmax = 90;  gm = 8; sm = 1; end
        4: begin per = 50;  gap = 400;   tmo = 20000; seed = 700;  n = 300;
                 bmin = 10;  bmax = 30;  gm = 0; sm = 2; end
        default: begin per = 255; gap = 65000; tmo = 65535; seed = 512; n = 150;
                 bmin = 200; bmax = 270; gm = 4; sm = 0; end
      endcase
      write_reg(REG_PERIOD, 16'(per));
      write_reg(REG_GAP, 16'(gap));
      write_reg(REG_TIMEOUT, 16'(tmo));
      write_reg(REG_SEED, 16'(seed));
      @(negedge clk_i);
      gap_max = gm;
      sink_mode = sm;
      pulse_train(n, bmin, bmax);
      // output held off long enough that the block backs up into its input
      if (p == 3) hold_cycles = 300;
      @(posedge clk_i);
      wait_drained();
    end

    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
